>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hw/rtl/utu_pkg.sv
// shared types and constants of the utf-8 to utf-16 converter
package utu_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] SURR_HI     = 16'hD800;
  localparam logic [15:0] SURR_LO     = 16'hDC00;

  localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE = 21'h010000;

  localparam logic [7:0] LEAD_TOO_HIGH = 8'hF8;

  // up to two code units produced by one input byte
  typedef struct packed {
    logic        done;
    logic        failed;
    logic        two;
    logic [15:0] u1;
    logic [15:0] u0;
  } pkt_t;

  // smallest code point allowed for a given trail count
  function automatic logic [20:0] min_for_trails(logic [1:0] n);
    logic [20:0] r;
    case (n)
      2'd1:    r = 21'h000080;
      2'd2:    r = 21'h000800;
      2'd3:    r = 21'h010000;
      default: r = 21'h1FFFFF; // no open sequence
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/utf8_to_utf16_converter.sv
// utf-8 to utf-16 converter top level
//
//  channel   dir  tdata               tuser    tlast
//  s_axis    in   [7:0] data_byte     -        end_of_input
//  m_axis    out  [15:0] code_unit    failed   stream_done
//  cfg       in   cfg_wdata_i = strict_mode, written when cfg_we_i is high
//
// one byte is accepted per cycle while the packet queue is not full; a byte that
// yields a surrogate pair, or a failure plus a retried lead, gives two code units
// the code units of an accepted byte pass through the packet queue and then the
// output register
// the four-entry packet queue takes up output stalls; s_axis_tready drops
// only when it is full
// reset clears sequence state, halt flag, strict mode and the queue; no
// clearing pass is needed

module utf8_to_utf16_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_input
  // output code units
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tuser,   // [0] failed
  output logic        m_axis_tlast,   // stream_done
  // strict mode register
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  // decoder to queue
  logic          push;
  logic          full;
  utu_pkg::pkt_t push_pkt;

  // queue to output stage
  logic          q_valid;
  logic          pop;
  utu_pkg::pkt_t q_pkt;

  // front: decode every accepted byte into zero, one or two code units
  utu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .pkt_o       (push_pkt)
  );

  // decouples decoder from output back pressure
  utu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (push_pkt),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .pkt_o   (q_pkt)
  );

  // back: serialize packets onto the output stream
  utu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .pkt_i       (q_pkt),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> hw/rtl/utu_front.sv
// byte decoder: sequence tracking, validation and code unit generation
`include "assert_macros.svh"

module utu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          full_i,
  output logic          push_o,
  output utu_pkg::pkt_t pkt_o
);

  logic        strict_q;
  logic [20:0] acc_q, acc_d;
  logic [1:0]  tl_q, tl_d;
  logic [1:0]  st_q, st_d;
  logic        lth_q, lth_d;
  logic        halt_q, halt_d;

  logic        accept;
  logic        is_cont;
  logic [1:0]  lead_n;
  logic [20:0] lead_acc;
  logic [20:0] acc_shift;
  logic [20:0] supp;
  logic [15:0] unit_c [2];
  logic [1:0]  cnt_c;
  logic        stop_c;
  logic        take;

  assign accept     = in_valid_i & ~full_i;
  assign in_ready_o = ~full_i;

  assign is_cont   = (in_byte_i[7:6] == 2'b10);
  assign lead_n    = (in_byte_i[7:4] == 4'hF) ? 2'd3 :
                     (in_byte_i[7:5] == 3'b111) ? 2'd2 : 2'd1;
  assign lead_acc  = (lead_n == 2'd3) ? {18'd0, in_byte_i[2:0]} :
                     (lead_n == 2'd2) ? {17'd0, in_byte_i[3:0]} :
                                        {16'd0, in_byte_i[4:0]};
  assign acc_shift = {acc_q[14:0], in_byte_i[5:0]};
  assign supp      = acc_shift - utu_pkg::SUPP_BASE;

  always_comb begin
    unit_c[0] = 16'h0000;
    unit_c[1] = 16'h0000;
    cnt_c     = 2'd0;
    stop_c    = 1'b0;
    take      = 1'b0;
    acc_d     = acc_q;
    tl_d      = tl_q;
    st_d      = st_q;
    lth_d     = lth_q;
    halt_d    = halt_q;
    if (halt_q) begin
      // dropping bytes until the end of the stream
      halt_d = ~in_last_i;
    end else begin
      if (tl_q != 2'd0) begin
        if (is_cont) begin
          acc_d = acc_shift;
          tl_d  = tl_q - 2'd1;
          if (tl_q == 2'd1) begin
            if (acc_shift < utu_pkg::min_for_trails(st_q)) begin
              unit_c[cnt_c[0]] = strict_q ? 16'h0000 : utu_pkg::REPLACEMENT;
              cnt_c  = cnt_c + 2'd1;
              stop_c = stop_c | strict_q;
            end else if (acc_shift <= utu_pkg::BMP_MAX) begin
              unit_c[0] = acc_shift[15:0];
              cnt_c     = 2'd1;
            end else if (acc_shift > utu_pkg::CP_MAX || lth_q) begin
              unit_c[cnt_c[0]] = strict_q ? 16'h0000 : utu_pkg::REPLACEMENT;
              cnt_c  = cnt_c + 2'd1;
              stop_c = stop_c | strict_q;
            end else begin
              unit_c[0] = utu_pkg::SURR_HI | {6'd0, supp[19:10]};
              unit_c[1] = utu_pkg::SURR_LO | {6'd0, supp[9:0]};
              cnt_c     = 2'd2;
            end
          end
        end else begin
          // broken sequence, byte is retried as a lead unless in strict mode
          tl_d = 2'd0;
          unit_c[cnt_c[0]] = strict_q ? 16'h0000 : utu_pkg::REPLACEMENT;
          cnt_c  = cnt_c + 2'd1;
          stop_c = stop_c | strict_q;
          take   = ~strict_q;
        end
      end else begin
        take = 1'b1;
      end

      if (take) begin
        if (!in_byte_i[7]) begin
          unit_c[cnt_c[0]] = {8'd0, in_byte_i};
          cnt_c = cnt_c + 2'd1;
        end else if (is_cont) begin
          // bare continuation byte
          unit_c[cnt_c[0]] = strict_q ? 16'h0000 : utu_pkg::REPLACEMENT;
          cnt_c  = cnt_c + 2'd1;
          stop_c = stop_c | strict_q;
        end else begin
          acc_d = lead_acc;
          tl_d  = lead_n;
          st_d  = lead_n;
          lth_d = (in_byte_i >= utu_pkg::LEAD_TOO_HIGH);
        end
      end

      // sequence cut short by the end of the stream
      if (in_last_i && !stop_c && tl_d != 2'd0) begin
        tl_d = 2'd0;
        unit_c[cnt_c[0]] = strict_q ? 16'h0000 : utu_pkg::REPLACEMENT;
        cnt_c  = cnt_c + 2'd1;
        stop_c = stop_c | strict_q;
      end

      if (stop_c || in_last_i) begin
        acc_d = '0;
        tl_d  = 2'd0;
        st_d  = 2'd0;
        lth_d = 1'b0;
      end
      halt_d = stop_c & ~in_last_i;
    end
  end

  assign push_o       = accept & ~halt_q & (cnt_c != 2'd0);
  assign pkt_o.u0     = unit_c[0];
  assign pkt_o.u1     = unit_c[1];
  assign pkt_o.two    = (cnt_c == 2'd2);
  assign pkt_o.failed = stop_c;
  assign pkt_o.done   = stop_c | in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      acc_q    <= '0;
      tl_q     <= 2'd0;
      st_q     <= 2'd0;
      lth_q    <= 1'b0;
      halt_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        strict_q <= cfg_wdata_i;
      end
      if (accept) begin
        acc_q  <= acc_d;
        tl_q   <= tl_d;
        st_q   <= st_d;
        lth_q  <= lth_d;
        halt_q <= halt_d;
      end
    end
  end

  `ASSERT_PROP(a_fail_ends_stream, push_o && pkt_o.failed |-> pkt_o.done && !pkt_o.two, "strict error not a lone final result")
  `ASSERT_PROP(a_halt_needs_strict, accept && !halt_q && halt_d |-> strict_q, "halt entered outside strict mode")

endmodule

>>> hw/rtl/utu_queue.sv
// small fifo of decoded packets between decoder and output stage
`include "assert_macros.svh"

module utu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utu_pkg::pkt_t pkt_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output utu_pkg::pkt_t pkt_o
);

  utu_pkg::pkt_t             mem_q [utu_pkg::QDEPTH];
  logic [utu_pkg::QAW-1:0]   wr_q, rd_q;
  logic [utu_pkg::QAW:0]     cnt_q;

  assign full_o  = (cnt_q == (utu_pkg::QAW+1)'(utu_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign pkt_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "pop from empty queue")

endmodule

>>> hw/rtl/utu_back.sv
// output stage: sends one or two code units per packet
`include "assert_macros.svh"

module utu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  utu_pkg::pkt_t pkt_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   out_data_o,
  output logic          out_user_o,
  output logic          out_last_o
);

  utu_pkg::pkt_t pkt_q;
  logic          busy_q;
  logic          idx_q;
  logic          last_unit;
  logic          take_out;

  assign last_unit = idx_q | ~pkt_q.two;
  assign take_out  = busy_q & out_ready_i;
  assign pop_o     = valid_i & (~busy_q | (take_out & last_unit));

  assign out_valid_o = busy_q;
  assign out_data_o  = idx_q ? pkt_q.u1 : pkt_q.u0;
  assign out_user_o  = pkt_q.failed;
  assign out_last_o  = pkt_q.done & last_unit;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pkt_q <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 1'b0;
      end else if (take_out) begin
        if (last_unit) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= 1'b1;
        end
      end
    end
  end

  `ASSERT_PROP(a_pair_follows, take_out && !last_unit |=> busy_q && idx_q, "second surrogate lost")
  `ASSERT_NEVER(a_second_needs_pair, busy_q && idx_q && !pkt_q.two, "second unit of a single packet")

endmodule

>>> tb/utf8_to_utf16_converter_tb.sv
// self-checking testbench for the utf-8 to utf-16 converter: byte streams in, code units checked
`timescale 1ns / 100ps

module utf8_to_utf16_converter_tb;

  // expected output code units
  localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR        = 16'hD800;
  localparam logic [15:0] LOW_SURR         = 16'hDC00;
  localparam logic [15:0] NO_UNIT          = 16'h0000;

  // code point limits
  localparam logic [20:0] BMP_TOP     = 21'h00FFFF;
  localparam logic [20:0] UNICODE_TOP = 21'h10FFFF;
  localparam logic [20:0] PLANE1_BASE = 21'h010000;
  localparam logic [7:0]  HIGH_LEAD   = 8'hF8;

  // smallest legal code point per trail count, anything else always fails
  localparam int unsigned FLOOR_TWO   = 32'h0000_0080;
  localparam int unsigned FLOOR_THREE = 32'h0000_0800;
  localparam int unsigned FLOOR_FOUR  = 32'h0001_0000;
  localparam int unsigned FLOOR_NONE  = 32'h7FFF_FFFF;

  // run control
  localparam int unsigned PHASE_BYTES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;     // output register plus four-entry queue
  localparam int unsigned HOLD_AT_BYTES = 700;   // when the long output hold-off starts
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no byte or code unit accepted
  localparam int unsigned PRINT_LIMIT   = 30;

  // receiver stall patterns
  localparam int unsigned RX_OPEN   = 0;
  localparam int unsigned RX_HALF   = 1;
  localparam int unsigned RX_SPARSE = 2;
  localparam int unsigned RX_TOGGLE = 3;

  // kinds of malformed input mixed into the streams
  typedef enum int unsigned {
    BAD_RANDOM,
    BAD_BARE_CONT,
    BAD_LONE_LEAD,
    BAD_OVERLONG,
    BAD_TOO_BIG,
    BAD_HIGH_LEAD,
    BAD_CONT_RUN
  } flaw_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] code;
    logic        failed;
    logic        done;
  } unit_t;

  // dut ports, every input known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;

  // stimulus and expectation stores
  byte_item_t  pending_bytes[$];
  unit_t       expected_units[$];
  logic [7:0]  stream_buf[$];
  unit_t       step_units[$];
  unit_t       want;

  // decoder state mirrored by the predictor
  logic [20:0] accum_r       = '0;
  logic [1:0]  trails_left_r = '0;
  logic [1:0]  seq_trails_r  = '0;
  logic        lead_high_r   = 1'b0;
  logic        halted_r      = 1'b0;
  logic        strict_mode_r = 1'b0;
  logic        step_stopped;

  // sender and receiver pacing
  int unsigned gap_left    = 0;
  int unsigned burst_left  = 1;
  int unsigned rx_mode     = RX_OPEN;
  int unsigned mode_left   = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  // statistics
  int unsigned bytes_queued   = 0;
  int unsigned bytes_taken    = 0;
  int unsigned streams_taken  = 0;
  int unsigned units_checked  = 0;
  int unsigned strict_stops   = 0;
  int unsigned replacements   = 0;
  int unsigned pairs_expected = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_run       = 0;

  utf8_to_utf16_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  function automatic void emit_unit(logic [15:0] code, logic failed);
    unit_t u;
    u.code   = code;
    u.failed = failed;
    u.done   = 1'b0;
    step_units.push_back(u);
  endfunction

  // malformed input: replacement char, or in strict mode one error unit and a stop
  function automatic void raise_failure();
    if (strict_mode_r) begin
      emit_unit(NO_UNIT, 1'b1);
      step_stopped = 1'b1;
    end else begin
      emit_unit(REPLACEMENT_UNIT, 1'b0);
    end
  endfunction

  function automatic void clear_open_sequence();
    accum_r       = '0;
    trails_left_r = '0;
    seq_trails_r  = '0;
    lead_high_r   = 1'b0;
  endfunction

  // last trail byte seen: range checks, then one unit, a surrogate pair or a failure
  function automatic void close_sequence();
    int unsigned floor_cp;
    logic [20:0] offset;
    case (seq_trails_r)
      2'd1:    floor_cp = FLOOR_TWO;
      2'd2:    floor_cp = FLOOR_THREE;
      2'd3:    floor_cp = FLOOR_FOUR;
      default: floor_cp = FLOOR_NONE;
    endcase
    if (accum_r < floor_cp) begin
      raise_failure();                       // overlong form
    end else if (accum_r <= BMP_TOP) begin
      emit_unit(accum_r[15:0], 1'b0);        // surrogates pass through as well
    end else if (accum_r > UNICODE_TOP || lead_high_r) begin
      raise_failure();
    end else begin
      offset = accum_r - PLANE1_BASE;
      emit_unit(HIGH_SURR | offset[19:10], 1'b0);
      emit_unit(LOW_SURR | offset[9:0], 1'b0);
      pairs_expected++;
    end
  endfunction

  // byte taken with no sequence open
  function automatic void begin_sequence(logic [7:0] b);
    logic [1:0] extra;
    if (!b[7]) begin
      emit_unit({8'h00, b}, 1'b0);
    end else if (b[7:6] == 2'b10) begin
      raise_failure();                       // bare continuation
    end else begin
      extra         = 2'd1 + 2'(b[7:5] == 3'b111) + 2'(b[7:4] == 4'b1111);
      accum_r       = {13'h0, b & (8'h3F >> extra)};
      trails_left_r = extra;
      seq_trails_r  = extra;
      lead_high_r   = (b >= HIGH_LEAD);
    end
  endfunction

  // one accepted byte request: update state and queue the units it causes
  function automatic void decode_byte(logic [7:0] b, logic eoi);
    step_units.delete();
    step_stopped = 1'b0;
    if (halted_r) begin
      // dropping bytes after a strict error, end byte clears the halt
      if (eoi) halted_r = 1'b0;
    end else begin
      if (trails_left_r != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          accum_r       = {accum_r[14:0], b[5:0]};
          trails_left_r = trails_left_r - 2'd1;
          if (trails_left_r == 2'd0) close_sequence();
        end else begin
          // broken sequence, the byte is retried as a new lead unless strict mode stopped
          trails_left_r = 2'd0;
          raise_failure();
          if (!step_stopped) begin_sequence(b);
        end
      end else begin
        begin_sequence(b);
      end
      // sequence cut short by the end of input
      if (eoi && !step_stopped && trails_left_r != 2'd0) begin
        trails_left_r = 2'd0;
        raise_failure();
      end
      if (step_stopped) begin
        clear_open_sequence();
        halted_r = !eoi;
        strict_stops++;
      end else if (eoi) begin
        clear_open_sequence();
      end
      if ((step_stopped || eoi) && step_units.size() > 0)
        step_units[step_units.size() - 1].done = 1'b1;
      foreach (step_units[i]) begin
        if (step_units[i].code == REPLACEMENT_UNIT) replacements++;
        expected_units.push_back(step_units[i]);
      end
    end
  endfunction

  // ------------------------------------------------------------------
  // stimulus generation
  // ------------------------------------------------------------------

  function automatic void push_byte(logic [7:0] data, logic last);
    byte_item_t item;
    item.data = data;
    item.last = last;
    pending_bytes.push_back(item);
    bytes_queued++;
  endfunction

  function automatic logic [7:0] any_cont();
    return {2'b10, 6'($urandom)};
  endfunction

  // utf-8 encoding at a forced length, so overlong and too-big forms come out too
  function automatic void put_encoded(logic [20:0] cp, int unsigned len);
    case (len)
      1: stream_buf.push_back({1'b0, cp[6:0]});
      2: begin
        stream_buf.push_back({3'b110, cp[10:6]});
        stream_buf.push_back({2'b10, cp[5:0]});
      end
      3: begin
        stream_buf.push_back({4'b1110, cp[15:12]});
        stream_buf.push_back({2'b10, cp[11:6]});
        stream_buf.push_back({2'b10, cp[5:0]});
      end
      default: begin
        stream_buf.push_back({5'b11110, cp[20:18]});
        stream_buf.push_back({2'b10, cp[17:12]});
        stream_buf.push_back({2'b10, cp[11:6]});
        stream_buf.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_flaw();
    flaw_e      kind;
    logic [7:0] lead;
    kind = flaw_e'($urandom_range(0, 6));
    case (kind)
      BAD_RANDOM:    stream_buf.push_back(8'($urandom_range(0, 255)));
      BAD_BARE_CONT: stream_buf.push_back(any_cont());
      BAD_LONE_LEAD: begin
        // lead left open, the next char breaks it
        lead = 8'($urandom_range('hC2, 'hF4));
        stream_buf.push_back(lead);
        if (lead >= 8'hE0 && $urandom_range(0, 1) == 1) stream_buf.push_back(any_cont());
      end
      BAD_OVERLONG: begin
        case ($urandom_range(2, 4))
          2:       put_encoded(21'($urandom_range(0, 'h7F)), 2);
          3:       put_encoded(21'($urandom_range(0, 'h7FF)), 3);
          default: put_encoded(21'($urandom_range(0, 'hFFFF)), 4);
        endcase
      end
      BAD_TOO_BIG:   put_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      BAD_HIGH_LEAD: begin
        // f8 with 90 lands in the legal range and only the lead check rejects it
        lead = ($urandom_range(0, 1) == 1) ? HIGH_LEAD : {5'b11111, 3'($urandom)};
        stream_buf.push_back(lead);
        stream_buf.push_back(($urandom_range(0, 1) == 1) ? 8'h90 : any_cont());
        stream_buf.push_back(any_cont());
        stream_buf.push_back(any_cont());
      end
      default: begin
        repeat ($urandom_range(1, 3)) stream_buf.push_back(any_cont());
      end
    endcase
  endfunction

  // one stream: mostly well-formed chars, some malformed, sometimes cut short
  function automatic void add_stream();
    int unsigned pick;
    stream_buf.delete();
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      put_encoded(21'($urandom_range(0, 'h7F)), 1);
      else if (pick < 48) put_encoded(21'($urandom_range('h80, 'h7FF)), 2);
      else if (pick < 66) put_encoded(21'($urandom_range('h800, 'hFFFF)), 3);
      else if (pick < 82) put_encoded(21'($urandom_range('h10000, 'h10FFFF)), 4);
      else                add_flaw();
    end
    if ($urandom_range(0, 9) == 0) begin
      stream_buf.push_back(8'($urandom_range('hC2, 'hF4)));
      if ($urandom_range(0, 1) == 1) stream_buf.push_back(any_cont());
    end
    foreach (stream_buf[i]) push_byte(stream_buf[i], i == stream_buf.size() - 1);
  endfunction

  task automatic run_random(input int unsigned n_bytes);
    int unsigned goal;
    goal = bytes_queued + n_bytes;
    while (bytes_queued < goal) add_stream();
  endtask

  // strict mode only changes once everything in flight has drained
  task automatic write_strict(input logic mode);
    while (pending_bytes.size() != 0 || expected_units.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= mode;
    strict_mode_r  = mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] exp_val,
                                 input logic [15:0] got_val);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch on %s: expected %h, got %h (unit %0d, byte %0d)",
               field, exp_val, got_val, units_checked, bytes_taken);
    mismatches++;
  endtask

  // ------------------------------------------------------------------
  // byte driver: bursts of random length with random gaps
  // ------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      // byte request accepted at this edge: predict and retire it
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
        if (s_axis_tlast) streams_taken++;
        void'(pending_bytes.pop_front());
        bytes_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // stalled: the offered byte stays as it is
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_bytes[0].data;
        s_axis_tlast  <= pending_bytes[0].last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver: stall patterns plus one long hold-off to back up the queue
  // ------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT_BYTES) begin
      // sender keeps going, so the dut fills and drops s_axis_tready
      hold_done      = 1'b1;
      hold_left      = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(RX_OPEN, RX_TOGGLE);
        mode_left = $urandom_range(16, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // monitor: every accepted code unit against the oldest expectation
  // ------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_units.size() == 0) begin
        report_mismatch("code_unit with none expected", NO_UNIT, m_axis_tdata);
      end else begin
        want = expected_units.pop_front();
        if (m_axis_tdata !== want.code)
          report_mismatch("code_unit", want.code, m_axis_tdata);
        if (m_axis_tuser !== want.failed)
          report_mismatch("failed", 16'(want.failed), 16'(m_axis_tuser));
        if (m_axis_tlast !== want.done)
          report_mismatch("stream_done", 16'(want.done), 16'(m_axis_tlast));
      end
      units_checked++;
    end
  end

  // ------------------------------------------------------------------
  // watchdog: ends the run when no request moves for too long
  // ------------------------------------------------------------------

  initial begin
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("timeout: %0d bytes accepted, %0d units still expected",
             bytes_taken, expected_units.size());
    $display("utf8_to_utf16_converter verification failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // replacement mode, directed
    write_strict(1'b0);
    push_byte(8'h7F, 1'b0);                                   // top ascii
    push_byte(8'hC2, 1'b0); push_byte(8'h80, 1'b0);           // smallest two-byte
    push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0);           // largest three-byte
    push_byte(8'hBF, 1'b0);
    push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0);           // top code point, pair
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);           // overlong
    push_byte(8'hE2, 1'b0); push_byte(8'h41, 1'b0);           // broken, then retried lead
    push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0);           // above the unicode range
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF8, 1'b0); push_byte(8'h90, 1'b0);           // lead of f8 or more
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hE1, 1'b1);                                   // cut short at end of input

    // strict mode, directed
    write_strict(1'b1);
    push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);           // error, stream halted
    push_byte(8'h41, 1'b1);                                   // end byte while halted
    push_byte(8'h80, 1'b1);                                   // error on the end byte
    push_byte(8'h41, 1'b1);

    // random streams, alternating modes
    for (int unsigned phase = 0; phase < 5; phase++) begin
      write_strict(1'(phase % 2));
      run_random(PHASE_BYTES);
    end

    while (pending_bytes.size() != 0 || expected_units.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d bytes in %0d streams, %0d code units checked",
             bytes_taken, streams_taken, units_checked);
    $display("both modes: %0d strict stops, %0d replacements, %0d surrogate pairs",
             strict_stops, replacements, pairs_expected);
    if (mismatches == 0) begin
      $display("utf8_to_utf16_converter verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("utf8_to_utf16_converter verification failed");
    end
    $finish;
  end

endmodule
